@@ rtl/core/lir_pkg.sv @@
// lir_pkg: shared types, sizes and codes of the linear interpolation resampler
// used by every module under rtl/core; depends on nothing

package lir_pkg;

  // block sizes
  localparam int MAX_RUN    = 64;
  localparam int MAX_POINTS = 4096;

  localparam int POS_W = 32;
  localparam int AMP_W = 24;
  localparam int IDX_W = 12;
  localparam int STEP_W = 31;

  localparam int IDX_CAP_INT = (MAX_POINTS - 1 < 4095) ? MAX_POINTS - 1 : 4095;
  localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(IDX_CAP_INT);

  localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

  // command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  // divider sizes: full quotient for grid searches, short one for interpolation
  localparam int DIV_Q_W  = 33;
  localparam int DIV_R_W  = 32;
  localparam int ITER_W   = 6;
  localparam logic [ITER_W-1:0] DIV_ITERS_FULL   = ITER_W'(DIV_Q_W);
  localparam logic [ITER_W-1:0] DIV_ITERS_INTERP = ITER_W'(AMP_W);

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRID_STEP  = 2'd1;

  localparam logic [STEP_W-1:0] GRID_STEP_RESET = 31'd66;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [AMP_W-1:0] amplitude;
    logic                    last_point;
  } in_item_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] interp_amp;
    logic [IDX_W-1:0]        grid_index;
    logic                    last_of_run;
    logic                    run_overflow;
  } out_item_t;

  // one classified point, as handed from front to back
  typedef struct packed {
    logic                    first;
    logic                    last;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] prev_position;
    logic signed [AMP_W-1:0] prev_amplitude;
    logic signed [AMP_W:0]   delta_amp;
    logic signed [POS_W:0]   delta_pos;
  } cmd_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_R_W-1:0]   rem_init;
    logic [DIV_Q_W-1:0]   dividend;
    logic [DIV_R_W-1:0]   divisor;
    logic [ITER_W-1:0]    iters;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_Q_W-1:0]   quotient;
    logic [DIV_R_W-1:0]   remainder;
  } div_resp_t;

endpackage

@@ rtl/core/lir_front.sv @@
// lir_front: accepts input points, tracks series start and the previous point
// depends on lir_pkg

module lir_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  lir_pkg::in_item_t in_item,
  output lir_pkg::cmd_t     cmd
);

  logic                            have_first_point;
  logic signed [lir_pkg::POS_W-1:0] prev_position;
  logic signed [lir_pkg::AMP_W-1:0] prev_amplitude;

  // classify the point against the previous one
  always_comb begin
    cmd.first          = !have_first_point;
    cmd.last           = in_item.last_point;
    cmd.position       = in_item.position;
    cmd.prev_position  = prev_position;
    cmd.prev_amplitude = prev_amplitude;
    cmd.delta_amp      = (lir_pkg::AMP_W+1)'($signed(in_item.amplitude))
                         - (lir_pkg::AMP_W+1)'($signed(prev_amplitude));
    cmd.delta_pos      = (lir_pkg::POS_W+1)'($signed(in_item.position))
                         - (lir_pkg::POS_W+1)'($signed(prev_position));
  end

  // series tracking, re-armed by a last point
  always_ff @(posedge clk) begin
    if (rst) begin
      have_first_point <= 1'b0;
      prev_position    <= '0;
      prev_amplitude   <= '0;
    end else if (accept) begin
      have_first_point <= !in_item.last_point;
      prev_position    <= in_item.position;
      prev_amplitude   <= in_item.amplitude;
    end
  end

endmodule

@@ rtl/core/lir_cmd_fifo.sv @@
// lir_cmd_fifo: short queue of classified points between front and back
// depends on lir_pkg

module lir_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lir_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output lir_pkg::cmd_t rdata,
  output logic          empty
);

  lir_pkg::cmd_t                   entries [lir_pkg::CMD_DEPTH];
  logic [lir_pkg::CMD_PTR_W-1:0]   wr_ptr;
  logic [lir_pkg::CMD_PTR_W-1:0]   rd_ptr;
  logic [lir_pkg::CMD_PTR_W:0]     count;

  assign full  = (count == (lir_pkg::CMD_PTR_W+1)'(lir_pkg::CMD_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= lir_pkg::CMD_PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= lir_pkg::CMD_PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= (lir_pkg::CMD_PTR_W+1)'(count + 1'b1);
      end else if (pop && !push) begin
        count <= (lir_pkg::CMD_PTR_W+1)'(count - 1'b1);
      end
    end
  end

endmodule

@@ rtl/core/lir_divider.sv @@
// lir_divider: restoring unsigned divider, one quotient bit per cycle
// depends on lir_pkg; the remainder preload must be below the divisor

module lir_divider (
  input  logic               clk,
  input  logic               rst,
  input  lir_pkg::div_req_t  req,
  output lir_pkg::div_resp_t resp
);

  logic [lir_pkg::DIV_R_W-1:0]  rem;
  logic [lir_pkg::DIV_Q_W-1:0]  dvd;
  logic [lir_pkg::DIV_Q_W-1:0]  quo;
  logic [lir_pkg::DIV_R_W-1:0]  divisor;
  logic [lir_pkg::ITER_W-1:0]   count;
  logic                         busy;
  logic                         done;

  logic [lir_pkg::DIV_R_W:0]    rem_shift;
  logic                         fits;

  // one trial subtraction
  assign rem_shift = {rem, dvd[lir_pkg::DIV_Q_W-1]};
  assign fits      = (rem_shift >= {1'b0, divisor});

  assign resp.busy      = busy;
  assign resp.done      = done;
  assign resp.quotient  = quo;
  assign resp.remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy  <= 1'b1;
        count <= req.iters;
      end else if (busy) begin
        count <= lir_pkg::ITER_W'(count - 1'b1);
        if (count == lir_pkg::ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath shift registers
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem     <= req.rem_init;
      dvd     <= req.dividend;
      divisor <= req.divisor;
      quo     <= '0;
    end else if (busy) begin
      rem <= fits ? lir_pkg::DIV_R_W'(rem_shift - {1'b0, divisor})
                  : rem_shift[lir_pkg::DIV_R_W-1:0];
      dvd <= {dvd[lir_pkg::DIV_Q_W-2:0], 1'b0};
      quo <= {quo[lir_pkg::DIV_Q_W-2:0], fits};
    end
  end

endmodule

@@ rtl/core/lir_back.sv @@
// lir_back: walks grid points through each segment and forms the results
// depends on lir_pkg; drives the shared lir_divider through div_req/div_resp

module lir_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [lir_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lir_pkg::POS_W-1:0]         cfg_data,
  input  lir_pkg::cmd_t                     cmd_rdata,
  input  logic                              cmd_empty,
  output logic                              cmd_pop,
  output lir_pkg::div_req_t                 div_req,
  input  lir_pkg::div_resp_t                div_resp,
  output lir_pkg::out_item_t                res,
  output logic                              res_valid,
  input  logic                              res_pop
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_FIRST_DIV,
    ST_SEG_SETUP,
    ST_LOOP,
    ST_MUL,
    ST_DIV_GO,
    ST_INTERP_DIV,
    ST_EMIT,
    ST_SKIP_DIV,
    ST_FINISH
  } state_t;

  state_t state;

  logic signed [lir_pkg::POS_W-1:0]  grid_start;
  logic [lir_pkg::STEP_W-1:0]        grid_step;

  lir_pkg::cmd_t                     cmd;
  logic signed [lir_pkg::POS_W:0]    ngp;
  logic [lir_pkg::IDX_W-1:0]         emitted_count;
  logic [lir_pkg::RUN_CNT_W-1:0]     n;
  logic                              overflow;
  logic [lir_pkg::AMP_W-1:0]         val;
  logic [55:0]                       prod;

  // working values, mostly in 34-bit signed; gap and run span in 39 bits
  logic [lir_pkg::STEP_W-1:0]  step_val;
  logic signed [33:0]          pos_w;
  logic signed [33:0]          ngp_w;
  logic signed [33:0]          step_w;
  logic signed [33:0]          start_w;
  logic signed [33:0]          prev_w;
  logic signed [33:0]          rem_w;
  logic signed [33:0]          next_w;
  logic signed [38:0]          gap_w;
  logic [38:0]                 run_span;
  logic                        grid_hit;
  logic                        pos_len;
  logic [lir_pkg::POS_W-1:0]   offset;
  logic [lir_pkg::AMP_W:0]     da_neg;
  logic [lir_pkg::AMP_W-1:0]   da_mag;
  logic [lir_pkg::AMP_W-1:0]   q_amp;
  logic [34:0]                 ec_sum;
  logic                        div_go;
  logic                        emit_fire;

  assign step_val = (grid_step == '0) ? lir_pkg::STEP_W'(1) : grid_step;
  assign pos_w    = 34'($signed(cmd.position));
  assign ngp_w    = 34'(ngp);
  assign step_w   = {3'b000, step_val};
  assign start_w  = 34'(grid_start);
  assign prev_w   = 34'($signed(cmd.prev_position));
  assign rem_w    = {2'b00, div_resp.remainder};
  assign next_w   = ngp_w + step_w;
  assign gap_w    = 39'(pos_w - ngp_w);
  assign run_span = 39'(step_val) * 39'(lir_pkg::MAX_RUN);
  assign grid_hit = (ngp_w <= pos_w);
  assign pos_len  = !cmd.delta_pos[lir_pkg::POS_W] && (cmd.delta_pos != '0);
  assign offset   = lir_pkg::POS_W'(ngp_w - prev_w);
  assign da_neg   = -cmd.delta_amp;
  assign da_mag   = cmd.delta_amp[lir_pkg::AMP_W] ? da_neg[lir_pkg::AMP_W-1:0]
                                                  : cmd.delta_amp[lir_pkg::AMP_W-1:0];
  assign q_amp    = div_resp.quotient[lir_pkg::AMP_W-1:0];
  assign ec_sum   = 35'(emitted_count) + 35'(div_resp.quotient) + 35'd1;

  // divider launches: grid search, skip over dropped points, interpolation
  assign div_go    = ((state == ST_FIRST) && (start_w < pos_w))
                     || ((state == ST_LOOP) && grid_hit
                         && (n >= lir_pkg::RUN_CNT_W'(lir_pkg::MAX_RUN)))
                     || (state == ST_DIV_GO);
  assign emit_fire = (state == ST_EMIT) && (!res_valid || res_pop);

  assign cmd_pop  = (state == ST_IDLE) && !cmd_empty;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_start <= '0;
      grid_step  <= lir_pkg::GRID_STEP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lir_pkg::CFG_GRID_START: grid_start <= $signed(cfg_data);
        lir_pkg::CFG_GRID_STEP:  grid_step  <= cfg_data[lir_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer with its registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ngp           <= '0;
      emitted_count <= '0;
      n             <= '0;
      overflow      <= 1'b0;
      res_valid     <= 1'b0;
      div_req       <= '0;
    end else begin
      div_req.start <= div_go;
      if (emit_fire) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!cmd_empty) begin
            cmd   <= cmd_rdata;
            state <= cmd_rdata.first ? ST_FIRST : ST_SEG_SETUP;
          end
        end
        // grid pointer to the first grid point at or after the position
        ST_FIRST: begin
          emitted_count <= '0;
          if (start_w < pos_w) begin
            div_req.rem_init <= '0;
            div_req.dividend <= lir_pkg::DIV_Q_W'(pos_w - start_w + step_w - 34'sd1);
            div_req.divisor  <= lir_pkg::DIV_R_W'(step_val);
            div_req.iters    <= lir_pkg::DIV_ITERS_FULL;
            state            <= ST_FIRST_DIV;
          end else begin
            ngp   <= (lir_pkg::POS_W+1)'(start_w);
            state <= ST_FINISH;
          end
        end
        ST_FIRST_DIV: begin
          if (div_resp.done) begin
            ngp   <= (lir_pkg::POS_W+1)'(pos_w + step_w - 34'sd1 - rem_w);
            state <= ST_FINISH;
          end
        end
        // a run longer than the limit flags every result of the segment
        ST_SEG_SETUP: begin
          overflow <= !gap_w[38] && (unsigned'(gap_w) >= run_span);
          n        <= '0;
          state    <= ST_LOOP;
        end
        ST_LOOP: begin
          if (grid_hit && (n < lir_pkg::RUN_CNT_W'(lir_pkg::MAX_RUN))) begin
            if (pos_len) begin
              state <= ST_MUL;
            end else begin
              val   <= cmd.prev_amplitude;
              state <= ST_EMIT;
            end
          end else if (grid_hit) begin
            div_req.rem_init <= '0;
            div_req.dividend <= lir_pkg::DIV_Q_W'(pos_w - ngp_w);
            div_req.divisor  <= lir_pkg::DIV_R_W'(step_val);
            div_req.iters    <= lir_pkg::DIV_ITERS_FULL;
            state            <= ST_SKIP_DIV;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_MUL: begin
          prod  <= 56'(da_mag) * 56'(offset);
          state <= ST_DIV_GO;
        end
        // quotient is below the amplitude step, so the top bits preload the remainder
        ST_DIV_GO: begin
          div_req.rem_init <= prod[55:lir_pkg::AMP_W];
          div_req.dividend <= {prod[lir_pkg::AMP_W-1:0],
                               (lir_pkg::DIV_Q_W-lir_pkg::AMP_W)'(0)};
          div_req.divisor  <= lir_pkg::DIV_R_W'(cmd.delta_pos);
          div_req.iters    <= lir_pkg::DIV_ITERS_INTERP;
          state            <= ST_INTERP_DIV;
        end
        ST_INTERP_DIV: begin
          if (div_resp.done) begin
            val   <= cmd.delta_amp[lir_pkg::AMP_W]
                     ? lir_pkg::AMP_W'(cmd.prev_amplitude - q_amp)
                     : lir_pkg::AMP_W'(cmd.prev_amplitude + q_amp);
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_fire) begin
            res.interp_amp    <= $signed(val);
            res.grid_index    <= emitted_count;
            res.last_of_run   <= (next_w > pos_w)
                                 || (n == lir_pkg::RUN_CNT_W'(lir_pkg::MAX_RUN - 1));
            res.run_overflow  <= overflow;
            if (emitted_count < lir_pkg::IDX_CAP) begin
              emitted_count <= lir_pkg::IDX_W'(emitted_count + 1'b1);
            end
            ngp   <= (lir_pkg::POS_W+1)'(next_w);
            n     <= lir_pkg::RUN_CNT_W'(n + 1'b1);
            state <= ST_LOOP;
          end
        end
        // skip the dropped grid points of a long segment
        ST_SKIP_DIV: begin
          if (div_resp.done) begin
            ngp <= (lir_pkg::POS_W+1)'(pos_w - rem_w + step_w);
            if (ec_sum >= 35'(lir_pkg::IDX_CAP)) begin
              emitted_count <= lir_pkg::IDX_CAP;
            end else begin
              emitted_count <= ec_sum[lir_pkg::IDX_W-1:0];
            end
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (cmd.last) begin
            emitted_count <= '0;
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/linear_interp_regular_resampler.sv @@
// Linear interpolation resampler onto a regular grid (grid_start, grid_step, Q16.16).
// Points enter through a four-deep command queue and are worked off one at a time
// by the back end, which uses the shared one-bit-per-cycle divider:
// the first point of a series only places the grid pointer, searching the grid
// forward by a 33-step division when needed; every later point forms each result
// by a multiply, then a 24-step division (neither when the segment has zero
// length); a 33-step division skips the rest when a segment holds more than
// MAX_RUN grid points. Results wait in a one-entry output register; the back
// end stalls there while it is full. A zero grid_step behaves as 1.
// depends on lir_pkg, lir_front, lir_cmd_fifo, lir_divider, lir_back

module linear_interp_regular_resampler (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  lir_pkg::in_item_t                 in_data,
  output logic                              empty,
  input  logic                              pop,
  output lir_pkg::out_item_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [lir_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lir_pkg::POS_W-1:0]         cfg_data
);

  logic               accept;
  lir_pkg::cmd_t      front_cmd;
  lir_pkg::cmd_t      cmd_rdata;
  logic               cmd_empty;
  logic               cmd_pop;
  lir_pkg::div_req_t  div_req;
  lir_pkg::div_resp_t div_resp;
  logic               res_valid;
  logic               res_pop;

  assign accept  = push && !full;
  assign empty   = !res_valid;
  assign res_pop = pop && res_valid;

  lir_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_item (in_data),
    .cmd     (front_cmd)
  );

  lir_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wdata (front_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  lir_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  lir_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_rdata (cmd_rdata),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .div_req   (div_req),
    .div_resp  (div_resp),
    .res       (out_data),
    .res_valid (res_valid),
    .res_pop   (res_pop)
  );

  // back end never takes a request from an empty queue
  assert property (@(posedge clk) disable iff (rst) cmd_pop |-> !cmd_empty)
    else $error("command queue popped while empty");

  // divider is started only when it is free
  assert property (@(posedge clk) disable iff (rst) div_req.start |-> !div_resp.busy)
    else $error("divider started while busy");

  // completion follows a running division
  assert property (@(posedge clk) disable iff (rst) div_resp.done |-> $past(div_resp.busy))
    else $error("divider done without a running division");

  // a division begins only on a start request
  assert property (@(posedge clk) disable iff (rst) $rose(div_resp.busy) |-> $past(div_req.start))
    else $error("divider went busy without a start");

endmodule

@@ sim/lir_resample_checker.sv @@
`timescale 1ns / 1ps
// lir_resample_checker: watches the request, result and register ports of the resampler,
// predicts every interpolated output and compares it field by field
// depends on lir_pkg

module lir_resample_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  lir_pkg::in_item_t               in_data,
  input  logic                            empty,
  input  logic                            pop,
  input  lir_pkg::out_item_t              out_data,
  input  logic                            cfg_wr_en,
  input  logic [lir_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lir_pkg::POS_W-1:0]       cfg_data,
  input  logic                            final_check,
  output int                              mismatches,
  output int                              pending,
  output int                              results_checked,
  output int                              truncated_results
);

  import lir_pkg::*;

  // register copies
  longint            grid_origin;
  logic [STEP_W-1:0] grid_spacing;

  // series state
  bit     series_open;
  longint next_grid;
  longint prev_pos;
  longint prev_amp;
  longint index_count;
  bit     final_done;

  out_item_t expected_outputs[$];

  initial begin
    mismatches        = 0;
    pending           = 0;
    results_checked   = 0;
    truncated_results = 0;
    final_done        = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // one request: walk the grid points of its segment and queue their outputs
  task automatic resample_point(input in_item_t pt);
    longint    pos;
    longint    amp;
    longint    step;
    longint    dx;
    longint    da;
    longint    v;
    longint    k;
    longint    x;
    int        n;
    out_item_t r;
    out_item_t run_buf[$];
    pos  = longint'($signed(pt.position));
    amp  = longint'($signed(pt.amplitude));
    step = (grid_spacing == '0) ? 1 : longint'(grid_spacing);
    n    = 0;
    if (!series_open) begin
      // first point of a series: find the first grid point at or after it
      x = grid_origin;
      if (x < pos) begin
        k = (pos - x + step - 1) / step;
        x = x + k * step;
      end
      next_grid   = x;
      series_open = 1;
      index_count = 0;
    end else begin
      dx = pos - prev_pos;
      da = amp - prev_amp;
      while (next_grid <= pos && n < MAX_RUN) begin
        v = prev_amp;
        if (dx > 0) v = v + (da * (next_grid - prev_pos)) / dx;
        r.interp_amp    = v[AMP_W-1:0];
        r.grid_index    = index_count[IDX_W-1:0];
        r.last_of_run   = 1'b0;
        r.run_overflow  = 1'b0;
        run_buf.push_back(r);
        if (index_count < IDX_CAP_INT) index_count++;
        next_grid = next_grid + step;
        n++;
      end
      // run cut off: skip the rest of the segment, index keeps counting
      if (next_grid <= pos) begin
        k = (pos - next_grid) / step + 1;
        next_grid = next_grid + k * step;
        if (k >= IDX_CAP_INT - index_count) index_count = IDX_CAP_INT;
        else index_count = index_count + k;
        foreach (run_buf[i]) run_buf[i].run_overflow = 1'b1;
      end
      if (n > 0) run_buf[n-1].last_of_run = 1'b1;
      foreach (run_buf[i]) expected_outputs.push_back(run_buf[i]);
    end
    prev_pos = pos;
    prev_amp = amp;
    if (pt.last_point) begin
      series_open = 0;
      index_count = 0;
    end
  endtask

  task automatic check_output(input out_item_t got);
    out_item_t want;
    if (expected_outputs.size() == 0) begin
      report_mismatch("output with none outstanding, interp_amp",
                      $signed(got.interp_amp), 0);
    end else begin
      want = expected_outputs.pop_front();
      results_checked++;
      if (want.run_overflow) truncated_results++;
      if (got.interp_amp !== want.interp_amp)
        report_mismatch("interp_amp", $signed(got.interp_amp), $signed(want.interp_amp));
      if (got.grid_index !== want.grid_index)
        report_mismatch("grid_index", got.grid_index, want.grid_index);
      if (got.last_of_run !== want.last_of_run)
        report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
      if (got.run_overflow !== want.run_overflow)
        report_mismatch("run_overflow", got.run_overflow, want.run_overflow);
    end
  endtask

  // sample all channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      grid_origin  = 0;
      grid_spacing = GRID_STEP_RESET;
      series_open  = 0;
      next_grid    = 0;
      prev_pos     = 0;
      prev_amp     = 0;
      index_count  = 0;
      expected_outputs.delete();
    end else begin
      if (pop && !empty) check_output(out_data);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_GRID_START: grid_origin = longint'($signed(cfg_data));
          CFG_GRID_STEP:  grid_spacing = cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) resample_point(in_data);
      // outputs still outstanding when the run closes
      if (final_check && !final_done) begin
        final_done = 1;
        if (expected_outputs.size() != 0)
          report_mismatch("outputs never delivered, count", 0, expected_outputs.size());
      end
    end
    pending = expected_outputs.size();
  end

endmodule

@@ sim/linear_interp_regular_resampler_tb.sv @@
`timescale 1ns / 1ps
// linear_interp_regular_resampler_tb: clock, reset, request and pop traffic and register
// settings for the resampler; depends on lir_pkg, lir_resample_checker and the block

module linear_interp_regular_resampler_tb;

  import lir_pkg::*;

  localparam longint POS_MAX    = 64'sd2147483647;
  localparam longint POS_MIN    = -64'sd2147483648;
  localparam int     SETTLE_CYC = 300;
  localparam int     HOLD_CYC   = 400;
  localparam longint TIMEOUT_NS = 64'd200_000_000;

  // indexes past the two registers, written to show they are ignored
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   push;
  logic                   full;
  in_item_t               in_data;
  logic                   empty;
  logic                   pop;
  out_item_t              out_data;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [POS_W-1:0]       cfg_data;
  logic                   final_check;
  logic                   hold_go;
  logic                   quiet_tail;

  int mismatches;
  int pending;
  int results_checked;
  int truncated_results;
  int points_sent;
  int settings_used;

  longint cur_start;
  longint cur_step;

  linear_interp_regular_resampler dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lir_resample_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .in_data           (in_data),
    .empty             (empty),
    .pop               (pop),
    .out_data          (out_data),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .final_check       (final_check),
    .mismatches        (mismatches),
    .pending           (pending),
    .results_checked   (results_checked),
    .truncated_results (truncated_results)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #(TIMEOUT_NS);
    $display("simulation limit reached, %0d outputs still outstanding", pending);
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stall bursts, one long hold-off, none in the tail
  initial begin
    int burst;
    bit held;
    burst = 0;
    held  = 0;
    pop   = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (hold_go && !held) begin
        held = 1;
        pop <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
      end else if (burst > 0) begin
        burst--;
        pop <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic longint clamp_pos(input longint p);
    if (p > POS_MAX) return POS_MAX;
    if (p < POS_MIN) return POS_MIN;
    return p;
  endfunction

  function automatic longint rand_amp();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 64'sd8388607;
    if (sel == 1) return -64'sd8388608;
    return longint'($signed(24'($urandom)));
  endfunction

  function automatic in_item_t make_point(input longint pos, input longint amp, input logic last);
    in_item_t p;
    p.position   = pos[POS_W-1:0];
    p.amplitude  = amp[AMP_W-1:0];
    p.last_point = last;
    return p;
  endfunction

  // offer one request after an optional gap, hold it until accepted
  task automatic send_point(input in_item_t p);
    int gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    points_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [POS_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_grid(input longint start, input longint step);
    cur_start = start;
    cur_step  = step;
    cfg_write(CFG_GRID_START, start[POS_W-1:0]);
    cfg_write(CFG_GRID_STEP, step[POS_W-1:0]);
    settings_used++;
  endtask

  // let every outstanding output arrive, then give pointless requests time to retire
  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // random series: mostly ordinary segments, some flat, backward or overlong ones
  task automatic random_phase(input int n_items, input int pressure_at);
    longint step;
    longint pos;
    longint dx;
    int     left;
    int     sel;
    int     i;
    step = (cur_step == 0) ? 1 : cur_step;
    left = 0;
    pos  = 0;
    for (i = 0; i < n_items; i++) begin
      if (i == pressure_at) hold_go <= 1'b1;
      if (left == 0) begin
        left = $urandom_range(2, 16);
        if ($urandom_range(0, 7) == 0)
          pos = longint'(int'($urandom));
        else
          pos = cur_start + (longint'($urandom_range(0, 8)) - 2) * step
                + longint'($urandom_range(0, 3));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 8)       dx = -longint'($urandom_range(1, 5000));
        else if (sel < 16) dx = 0;
        else if (sel < 22) dx = step * longint'(MAX_RUN + $urandom_range(1, 40));
        else               dx = step * longint'($urandom_range(0, 5))
                                + longint'($urandom) % step;
        pos = pos + dx;
      end
      pos = clamp_pos(pos);
      left--;
      send_point(make_point(pos, rand_amp(), left == 0 || i == n_items - 1));
    end
  endtask

  // stimulus
  initial begin
    rst         = 1'b1;
    push        = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    final_check = 1'b0;
    hold_go     = 1'b0;
    quiet_tail  = 1'b0;
    points_sent = 0;
    settings_used = 1;
    cur_start   = 0;
    cur_step    = 66;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed cases on the reset grid
    send_point(make_point(100, 5, 1'b1));                        // lone point
    send_point(make_point(0, 0, 1'b0));                          // starts on a grid point
    send_point(make_point(0, 1000, 1'b0));                       // zero-length segment
    send_point(make_point(660, 8388607, 1'b0));                  // ten grid points
    send_point(make_point(5280, -8388608, 1'b0));                // run cut off
    send_point(make_point(1000, 123, 1'b0));                     // backward step
    send_point(make_point(330000, -5, 1'b0));                    // index saturates
    send_point(make_point(330198, 77, 1'b1));                    // saturated index emitted
    send_point(make_point(2147483000, -1, 1'b0));                // grid search near top
    send_point(make_point(POS_MAX, 8388607, 1'b1));
    send_point(make_point(POS_MIN, -8388608, 1'b0));             // start below grid origin
    send_point(make_point(-100, 0, 1'b0));
    send_point(make_point(200, 8388607, 1'b1));
    send_point(make_point(1, 7, 1'b0));
    send_point(make_point(66, -7, 1'b0));
    send_point(make_point(100, 3, 1'b1));
    random_phase(50, -1);
    drain();

    // finest grid from the bottom of the range
    apply_grid(POS_MIN, 1);
    random_phase(50, -1);
    drain();

    // coarsest grid at the top of the range
    apply_grid(POS_MAX, POS_MAX);
    random_phase(20, -1);
    drain();

    // zero spacing acts as one; spare indexes must not disturb anything
    apply_grid(longint'(int'($urandom)) / 2, 0);
    cfg_write(CFG_SPARE_LO, $urandom);
    cfg_write(CFG_SPARE_HI, $urandom);
    random_phase(40, -1);
    drain();

    // random spacing, with the result side held off long enough to fill the block
    apply_grid(longint'(int'($urandom)) / 2, longint'($urandom_range(256, 1 << 20)));
    random_phase(120, 40);
    drain();

    // unit spacing at full rate on both sides
    quiet_tail <= 1'b1;
    apply_grid(longint'(int'($urandom)) / 2, 65536);
    random_phase(120, -1);
    drain();

    @(negedge clk);
    final_check <= 1'b1;
    @(negedge clk);
    $display("sent %0d points over %0d grid settings, incl. flat, backward, overlong segments",
             points_sent, settings_used);
    $display("compared %0d interpolated outputs, %0d of them from cut-off runs",
             results_checked, truncated_results);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/lir_pkg.sv
rtl/core/lir_front.sv
rtl/core/lir_cmd_fifo.sv
rtl/core/lir_divider.sv
rtl/core/lir_back.sv
rtl/core/linear_interp_regular_resampler.sv
sim/lir_resample_checker.sv
sim/linear_interp_regular_resampler_tb.sv
